@@ src/dvrt_pkg.sv @@
package dvrt_pkg;

  localparam int COST_W        = 10;
  localparam int HOP_W         = 3;
  localparam int NODE_W        = 4;
  localparam int MAX_NODES_DEF = 8;

  localparam logic [COST_W-1:0] NO_LINK = 10'd999;

  // one table entry as kept in the matrix memory
  typedef struct packed {
    logic              link;
    logic [HOP_W-1:0]  hop;
    logic [COST_W-1:0] cost;
  } entry_t;

  // verdict of one add-compare step
  typedef struct packed {
    logic              upd;
    logic [COST_W-1:0] via;
  } relax_t;

endpackage

@@ src/distance_vector_relax_table.sv @@
// Distance-vector table with one relaxation sweep. Load n*n link costs row-major,
// one item per cycle (999 or more means no link). The last cost starts one in-place
// sweep over source i, neighbor j, destination k through a single add-compare unit
// and a matrix memory with two read ports; a pair (i,j) gets a k pass only when i
// links to j. The table is then sent as n*n result items, row-major, the final one
// flagged by out_last_entry. No input is taken from the last cost until the last
// result is gone. A cfg_wr_en write sets the node count from cfg_wr_data and resets
// the row and column indices, which restarts a load in progress at its first entry.
module distance_vector_relax_table #(
  parameter int MAX_NODES = dvrt_pkg::MAX_NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [dvrt_pkg::NODE_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dvrt_pkg::COST_W-1:0]   in_link_cost,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dvrt_pkg::HOP_W-1:0]    out_source_router,
  output logic [dvrt_pkg::HOP_W-1:0]    out_destination_router,
  output logic [dvrt_pkg::HOP_W-1:0]    out_next_hop,
  output logic [dvrt_pkg::COST_W-1:0]   out_distance,
  output logic                          out_last_entry
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int HW     = dvrt_pkg::HOP_W;
  localparam int NW     = dvrt_pkg::NODE_W;

  typedef enum logic [2:0] {
    S_LOAD, S_JRD, S_JCHK, S_KRUN, S_KDRAIN, S_ORD, S_OLD, S_OWAIT
  } state_t;

  state_t                       state_r;
  logic [NW-1:0]                node_count_r;
  logic [IDX_W-1:0]             i_r, j_r, k_r, pk_r;
  logic [dvrt_pkg::COST_W-1:0]  cij_r;
  logic                         p_valid_r;
  logic                         out_valid_r;
  logic [HW-1:0]                src_r, dst_r, hop_r;
  logic [dvrt_pkg::COST_W-1:0]  dist_r;
  logic                         last_r;

  dvrt_pkg::entry_t             mem [DEPTH];
  dvrt_pkg::entry_t             rd_a_r, rd_b_r, wdata;
  logic                         we;
  logic [ADDR_W-1:0]            waddr, ra, rb;

  logic [NW-1:0]                n_m1;
  logic [IDX_W-1:0]             n_last;
  logic [dvrt_pkg::COST_W-1:0]  cost_sat;
  logic                         j_end, i_end;
  dvrt_pkg::relax_t             relax;

  // clamp node count: 0 acts as 1, above MAX_NODES acts as MAX_NODES
  always_comb begin
    if (node_count_r == '0) begin
      n_m1 = '0;
    end else if (node_count_r > NW'(MAX_NODES)) begin
      n_m1 = NW'(MAX_NODES - 1);
    end else begin
      n_m1 = node_count_r - NW'(1);
    end
  end
  assign n_last = n_m1[IDX_W-1:0];

  assign cost_sat = (in_link_cost > dvrt_pkg::NO_LINK) ? dvrt_pkg::NO_LINK : in_link_cost;
  assign j_end    = (j_r == n_last);
  assign i_end    = (i_r == n_last);

  dvrt_relax u_relax (
    .cost_ij (cij_r),
    .cost_jk (rd_b_r.cost),
    .cost_ik (rd_a_r.cost),
    .res     (relax)
  );

  // memory ports; row i's writes never hit row j != i reads, and the drain
  // state keeps the last write of a k pass off the next (i,j) read
  always_comb begin
    we    = 1'b0;
    waddr = {i_r, j_r};
    wdata = '0;
    ra    = (state_r == S_KRUN) ? {i_r, k_r} : {i_r, j_r};
    rb    = {j_r, k_r};
    if (state_r == S_LOAD && in_valid) begin
      we         = 1'b1;
      wdata.link = (cost_sat != dvrt_pkg::NO_LINK);
      wdata.hop  = HW'(i_r);
      wdata.cost = cost_sat;
    end else if (p_valid_r && relax.upd) begin
      we         = 1'b1;
      waddr      = {i_r, pk_r};
      wdata.link = rd_a_r.link;
      wdata.hop  = HW'(j_r);
      wdata.cost = relax.via;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      node_count_r <= NW'(MAX_NODES);
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      p_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      p_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (j_end) begin
              j_r <= '0;
              if (i_end) begin
                i_r     <= '0;
                state_r <= S_JRD;
              end else begin
                i_r <= i_r + 1'b1;
              end
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        S_JRD: state_r <= S_JCHK;
        S_JCHK: begin
          if (rd_a_r.link) begin
            cij_r   <= rd_a_r.cost;
            k_r     <= '0;
            state_r <= S_KRUN;
          end else if (j_end) begin
            j_r <= '0;
            if (i_end) begin
              i_r     <= '0;
              state_r <= S_ORD;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_JRD;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_JRD;
          end
        end
        S_KRUN: begin
          p_valid_r <= 1'b1;
          pk_r      <= k_r;
          if (k_r == n_last) begin
            state_r <= S_KDRAIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_KDRAIN: begin
          if (j_end) begin
            j_r <= '0;
            if (i_end) begin
              i_r     <= '0;
              state_r <= S_ORD;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_JRD;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_JRD;
          end
        end
        S_ORD: state_r <= S_OLD;
        S_OLD: begin
          src_r       <= HW'(i_r);
          dst_r       <= HW'(j_r);
          hop_r       <= rd_a_r.hop;
          dist_r      <= rd_a_r.cost;
          last_r      <= i_end && j_end;
          out_valid_r <= 1'b1;
          state_r     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (j_end) begin
              j_r <= '0;
              if (i_end) begin
                i_r     <= '0;
                state_r <= S_LOAD;
              end else begin
                i_r     <= i_r + 1'b1;
                state_r <= S_ORD;
              end
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_ORD;
            end
          end
        end
      endcase
      // new node count resets the indices, restarting a load in progress
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
        i_r          <= '0;
        j_r          <= '0;
      end
    end
  end

  assign in_ready               = (state_r == S_LOAD);
  assign out_valid              = out_valid_r;
  assign out_source_router      = src_r;
  assign out_destination_router = dst_r;
  assign out_next_hop           = hop_r;
  assign out_distance           = dist_r;
  assign out_last_entry         = last_r;

endmodule

@@ src/dvrt_relax.sv @@
module dvrt_relax (
  input  logic [dvrt_pkg::COST_W-1:0] cost_ij,
  input  logic [dvrt_pkg::COST_W-1:0] cost_jk,
  input  logic [dvrt_pkg::COST_W-1:0] cost_ik,
  output dvrt_pkg::relax_t            res
);

  logic [dvrt_pkg::COST_W:0] sum;

  assign sum = {1'b0, cost_ij} + {1'b0, cost_jk};

  // a win is always below cost_ik, so it fits back in COST_W bits
  assign res.upd = sum < {1'b0, cost_ik};
  assign res.via = sum[dvrt_pkg::COST_W-1:0];

endmodule

@@ src/dvrt_checker.sv @@
module dvrt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_wr_en,
  input logic [dvrt_pkg::NODE_W-1:0]  cfg_wr_data,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [dvrt_pkg::COST_W-1:0]  in_link_cost,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dvrt_pkg::HOP_W-1:0]   out_source_router,
  input logic [dvrt_pkg::HOP_W-1:0]   out_destination_router,
  input logic [dvrt_pkg::HOP_W-1:0]   out_next_hop,
  input logic [dvrt_pkg::COST_W-1:0]  out_distance,
  input logic                         out_last_entry
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) &&
      $stable(out_next_hop) && $stable(out_source_router) &&
      $stable(out_destination_router) && $stable(out_last_entry))
    else $error("result item changed while stalled");

  // loading and table output never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_entry |=> in_ready)
    else $error("not ready for a new matrix after the last entry");

  a_still_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_entry |=> !in_ready)
    else $error("input accepted before the table was fully sent");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= dvrt_pkg::NO_LINK)
    else $error("distance above the no-link value");

  // cfg and input payload are visible here but carry no checks of their own
  logic unused_ok;
  assign unused_ok = cfg_wr_en ^ (^cfg_wr_data) ^ in_valid ^ (^in_link_cost);

endmodule

bind distance_vector_relax_table dvrt_checker u_dvrt_checker (.*);

@@ tb/distance_vector_relax_table_test.sv @@
`timescale 1ns / 1ps

module distance_vector_relax_table_test;

  localparam int COST_W        = dvrt_pkg::COST_W;
  localparam int HOP_W         = dvrt_pkg::HOP_W;
  localparam int NODE_W        = dvrt_pkg::NODE_W;
  localparam int MAX_NODES_DEF = dvrt_pkg::MAX_NODES_DEF;
  localparam logic [dvrt_pkg::COST_W-1:0] NO_LINK = dvrt_pkg::NO_LINK;

  localparam int CELLS = MAX_NODES_DEF * MAX_NODES_DEF;

  typedef struct packed {
    logic [HOP_W-1:0]  src;
    logic [HOP_W-1:0]  dst;
    logic [HOP_W-1:0]  hop;
    logic [COST_W-1:0] distance;
    logic              is_last;
  } route_entry_t;

  // Tracks the loaded cost matrix and predicts the routing table after one sweep.
  class routing_table_tracker;
    logic [NODE_W-1:0]    node_reg;
    logic [COST_W-1:0]    cost_mem [CELLS];
    logic [HOP_W-1:0]     hop_mem  [CELLS];
    bit                   link_mem [CELLS];
    int unsigned          loaded;
    route_entry_t         pending_routes[$];
    int                   errors;
    int                   routes_checked;
    int                   tables_built;
    bit [MAX_NODES_DEF:1] sizes_seen;

    function new();
      node_reg = NODE_W'(MAX_NODES_DEF);
      loaded = 0;
      errors = 0;
      routes_checked = 0;
      tables_built = 0;
      sizes_seen = '0;
    endfunction

    function int unsigned active_nodes();
      if (node_reg == 0) return 1;
      if (node_reg > MAX_NODES_DEF) return MAX_NODES_DEF;
      return node_reg;
    endfunction

    function void take_config(logic [NODE_W-1:0] value);
      node_reg = value;
      loaded = 0;
    endfunction

    function void take_cost(logic [COST_W-1:0] raw);
      int unsigned n, total, via, i, j, k, ij, ik;
      logic [COST_W-1:0] cost;
      route_entry_t e;
      n = active_nodes();
      total = n * n;
      cost = (raw > NO_LINK) ? NO_LINK : raw;
      if (loaded >= total) loaded = 0;
      ij = (loaded / n) * MAX_NODES_DEF + loaded % n;
      cost_mem[ij] = cost;
      link_mem[ij] = (cost != NO_LINK);
      loaded++;
      if (loaded < total) return;
      loaded = 0;
      for (i = 0; i < n; i++)
        for (j = 0; j < n; j++)
          hop_mem[i * MAX_NODES_DEF + j] = HOP_W'(i);
      // in-place sweep: later steps see earlier updates
      for (i = 0; i < n; i++) begin
        for (j = 0; j < n; j++) begin
          ij = i * MAX_NODES_DEF + j;
          if (!link_mem[ij]) continue;
          for (k = 0; k < n; k++) begin
            ik = i * MAX_NODES_DEF + k;
            via = cost_mem[ij] + cost_mem[j * MAX_NODES_DEF + k];
            if (via < cost_mem[ik]) begin
              cost_mem[ik] = COST_W'(via);
              hop_mem[ik] = HOP_W'(j);
            end
          end
        end
      end
      for (i = 0; i < n; i++) begin
        for (j = 0; j < n; j++) begin
          e.src = HOP_W'(i);
          e.dst = HOP_W'(j);
          e.hop = hop_mem[i * MAX_NODES_DEF + j];
          e.distance = cost_mem[i * MAX_NODES_DEF + j];
          e.is_last = (i == n - 1) && (j == n - 1);
          pending_routes.push_back(e);
        end
      end
      tables_built++;
      sizes_seen[n] = 1'b1;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_route(route_entry_t got);
      route_entry_t want;
      if (pending_routes.size() == 0) begin
        $display("%0t: route entry expected none, got src %0d dst %0d hop %0d dist %0d last %0d",
                 $time, got.src, got.dst, got.hop, got.distance, got.is_last);
        errors++;
        return;
      end
      want = pending_routes.pop_front();
      check_field("source_router", want.src, got.src);
      check_field("destination_router", want.dst, got.dst);
      check_field("next_hop", want.hop, got.hop);
      check_field("distance", want.distance, got.distance);
      check_field("last_entry", want.is_last, got.is_last);
      routes_checked++;
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [NODE_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [COST_W-1:0] in_link_cost = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [HOP_W-1:0]  out_source_router;
  logic [HOP_W-1:0]  out_destination_router;
  logic [HOP_W-1:0]  out_next_hop;
  logic [COST_W-1:0] out_distance;
  logic              out_last_entry;

  routing_table_tracker board = new();
  bit no_idle = 1'b0;
  int items_sent = 0;
  int rx_hold = 0;

  distance_vector_relax_table DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_link_cost           (in_link_cost),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_source_router      (out_source_router),
    .out_destination_router (out_destination_router),
    .out_next_hop           (out_next_hop),
    .out_distance           (out_distance),
    .out_last_entry         (out_last_entry)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // diagonal entries lean toward zero, the rest spread over links, gaps and clipped costs
  function automatic logic [COST_W-1:0] draw_cost(bit diag);
    if (diag && $urandom_range(0, 3) != 0) return '0;
    case ($urandom_range(0, 9))
      0, 1:    return NO_LINK;
      2:       return COST_W'($urandom_range(1000, 1023));
      3:       return '0;
      4:       return COST_W'($urandom_range(500, 998));
      5:       return COST_W'($urandom_range(0, 1023));
      default: return COST_W'($urandom_range(1, 60));
    endcase
  endfunction

  // result side: random hold-off after each item taken
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        board.match_route({out_source_router, out_destination_router, out_next_hop,
                           out_distance, out_last_entry});
        rx_hold = draw_gap();
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_ready <= (rx_hold == 0);
    end
  end

  task automatic send_cost(input logic [COST_W-1:0] cost);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_link_cost <= cost;
    do @(posedge clk); while (!in_ready);
    board.take_cost(cost);
    items_sent++;
  endtask

  task automatic drain_routes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_routes.size() != 0) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [NODE_W-1:0] value);
    drain_routes();
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    board.take_config(value);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_table(input int unsigned n);
    int unsigned e;
    for (e = 0; e < n * n; e++) begin
      send_cost(draw_cost((e / n) == (e % n)));
      if ($urandom_range(0, 24) == 0) drain_routes();
    end
  endtask

  initial begin
    logic [COST_W-1:0] tri_net [9];
    logic [NODE_W-1:0] size_code;
    int unsigned n, tables, cut, e;
    int phase;

    // 0-1-2 chain: the ends reach each other only through node 1
    tri_net = '{10'd0, 10'd4, NO_LINK, 10'd4, 10'd0, 10'd2, 10'd1023, 10'd2, 10'd0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // partial load at the reset size, abandoned by a write of zero (one node)
    send_cost(10'd0);
    send_cost(10'd1023);
    send_cost(NO_LINK);
    write_node_count(4'd0);
    send_cost(10'd0);
    send_cost(NO_LINK);
    send_cost(10'd1023);
    send_cost(10'd1000);
    send_cost(10'd1);
    write_node_count(4'd3);
    foreach (tri_net[i]) send_cost(tri_net[i]);
    drain_routes();
    for (e = 0; e < 4; e++) send_cost(tri_net[e]);
    write_node_count(4'd2);
    send_cost(10'd5);
    send_cost(NO_LINK);
    send_cost(10'd1000);
    send_cost(10'd7);

    phase = 0;
    while (items_sent < 180) begin
      if (phase == 0) begin
        size_code = NODE_W'($urandom_range(8, 15));
      end else begin
        case ($urandom_range(0, 19))
          0, 1:    size_code = '0;
          2, 3:    size_code = NODE_W'($urandom_range(5, 7));
          4:       size_code = NODE_W'($urandom_range(8, 15));
          default: size_code = NODE_W'($urandom_range(1, 4));
        endcase
      end
      no_idle = ($urandom_range(0, 3) == 0);
      write_node_count(size_code);
      n = board.active_nodes();
      tables = (n <= 4) ? $urandom_range(1, 3) : 1;
      repeat (tables) send_table(n);
      // broken matrix, cut short by the next size write
      if (n > 1 && $urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, n * n - 1);
        for (e = 0; e < cut; e++) send_cost(draw_cost((e / n) == (e % n)));
      end
      phase++;
    end

    no_idle = 1'b0;
    drain_routes();
    repeat (20) @(posedge clk);
    $display("Run covered %0d cost items, %0d tables and %0d route entries checked.",
             items_sent, board.tables_built, board.routes_checked);
    $display("Node counts exercised (bit n set for n nodes): %b", board.sizes_seen);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dvrt_pkg.sv
src/dvrt_relax.sv
src/distance_vector_relax_table.sv
src/dvrt_checker.sv
tb/distance_vector_relax_table_test.sv
